// ===== hw/rtl/rti_pkg.sv =====
// Shared types, constants and fixed-point helpers for the ray/triangle intersect block.
package rti_pkg;

  localparam int FRAC_BITS = 16;
  localparam int FIX_W     = 32;
  localparam int NUM_W     = FIX_W + FRAC_BITS;   // dividend width, also divider stage count
  localparam int QDEPTH    = 8;
  localparam int QPTR_W    = $clog2(QDEPTH);
  localparam int QCNT_W    = QPTR_W + 1;
  localparam int CFG_IDX_W = 8;
  localparam int FRONT_STAGES = 4;
  localparam logic [15:0] DET_EPS_RESET = 16'd7;
  localparam logic signed [FIX_W+1:0] FIX_ONE = (FIX_W+2)'(1) <<< FRAC_BITS;

  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y    = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z    = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_DET_EPSILON = CFG_IDX_W'(3);

  typedef logic signed [FIX_W-1:0] fix_t;

  typedef struct packed {
    fix_t x;
    fix_t y;
    fix_t z;
  } vec_t;

  typedef struct packed {
    vec_t        origin;
    logic [15:0] eps;
  } cfg_t;

  // queue entry between front and back
  typedef struct packed {
    logic miss;
    fix_t det;
    fix_t nu;
    fix_t nv;
    fix_t nt;
  } qent_t;

  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [NUM_W-1:0] quo;
    logic [FIX_W:0]   rem;
  } div_lane_t;

  function automatic fix_t sat32(input logic signed [63:0] x);
    fix_t r;
    if (x > 64'sh0000_0000_7FFF_FFFF) r = 32'sh7FFF_FFFF;
    else if (x < -64'sh0000_0000_8000_0000) r = 32'sh8000_0000;
    else r = x[FIX_W-1:0];
    return r;
  endfunction

  function automatic logic signed [63:0] fmul_raw(input fix_t a, input fix_t b);
    logic signed [63:0] ea;
    logic signed [63:0] eb;
    ea = 64'(a);
    eb = 64'(b);
    return ea * eb;
  endfunction

  // floor shift of an exact product, saturated
  function automatic fix_t fixp(input logic signed [63:0] p);
    return sat32(p >>> FRAC_BITS);
  endfunction

  function automatic fix_t sub_sat(input fix_t a, input fix_t b);
    logic signed [63:0] ea;
    logic signed [63:0] eb;
    ea = 64'(a);
    eb = 64'(b);
    return sat32(ea - eb);
  endfunction

  function automatic fix_t add3_sat(input fix_t a, input fix_t b, input fix_t c);
    logic signed [63:0] ea;
    logic signed [63:0] eb;
    logic signed [63:0] ec;
    ea = 64'(a);
    eb = 64'(b);
    ec = 64'(c);
    return sat32(ea + eb + ec);
  endfunction

  function automatic logic [FIX_W-1:0] mag32(input fix_t a);
    logic [FIX_W-1:0] r;
    if (a[FIX_W-1]) r = FIX_W'(0) - a;
    else r = a;
    return r;
  endfunction

  // one restoring-division bit
  function automatic div_lane_t div_step(input div_lane_t a, input logic [FIX_W-1:0] d);
    div_lane_t  r;
    logic [FIX_W:0] r2;
    logic       qb;
    r2 = {a.rem[FIX_W-1:0], a.num[NUM_W-1]};
    qb = (r2 >= {1'b0, d});
    r.rem = qb ? (r2 - {1'b0, d}) : r2;
    r.quo = {a.quo[NUM_W-2:0], qb};
    r.num = {a.num[NUM_W-2:0], 1'b0};
    return r;
  endfunction

  // sign and saturate a quotient magnitude
  function automatic fix_t quo_sat(input logic [NUM_W-1:0] qm, input logic neg);
    fix_t r;
    if (!neg) begin
      if (|qm[NUM_W-1:FIX_W-1]) r = 32'sh7FFF_FFFF;
      else r = qm[FIX_W-1:0];
    end else begin
      if ((|qm[NUM_W-1:FIX_W]) || (qm[FIX_W-1] && (|qm[FIX_W-2:0]))) r = 32'sh8000_0000;
      else r = FIX_W'(0) - qm[FIX_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/rti_if.sv =====
// Handshake channel interfaces for the ray/triangle intersect block.
interface rti_in_if;
  import rti_pkg::*;
  logic valid;
  logic ready;
  fix_t dir_x;
  fix_t dir_y;
  fix_t dir_z;
  fix_t a_x;
  fix_t a_y;
  fix_t a_z;
  fix_t b_x;
  fix_t b_y;
  fix_t b_z;
  fix_t c_x;
  fix_t c_y;
  fix_t c_z;
  modport source (output valid, dir_x, dir_y, dir_z, a_x, a_y, a_z, b_x, b_y, b_z,
                  c_x, c_y, c_z, input ready);
  modport sink (input valid, dir_x, dir_y, dir_z, a_x, a_y, a_z, b_x, b_y, b_z,
                c_x, c_y, c_z, output ready);
endinterface

interface rti_out_if;
  import rti_pkg::*;
  logic valid;
  logic ready;
  logic hit;
  fix_t distance;
  fix_t bary_u;
  fix_t bary_v;
  modport source (output valid, hit, distance, bary_u, bary_v, input ready);
  modport sink (input valid, hit, distance, bary_u, bary_v, output ready);
endinterface

interface rti_cfg_if;
  import rti_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [FIX_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/rti_front.sv =====
// Front: edges, cross products, dot products and miss-by-determinant, four stages.
module rti_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  rti_pkg::vec_t         in_dir,
  input  rti_pkg::vec_t         in_a,
  input  rti_pkg::vec_t         in_b,
  input  rti_pkg::vec_t         in_c,
  input  rti_pkg::cfg_t         cfg,
  input  logic [rti_pkg::QCNT_W-1:0] q_count,
  output logic                  push,
  output rti_pkg::qent_t        push_data
);
  import rti_pkg::*;

  logic [FRONT_STAGES-1:0] v_r;
  logic [QCNT_W:0]         used;
  logic                    acc;

  vec_t dir1_r, e1_1_r, e2_1_r, s1_r;
  vec_t dir2_r, e1_2_r, e2_2_r, s2_r;
  vec_t dir3_r, e1_3_r, e2_3_r, s3_r;
  vec_t p3_r, q3_r;
  logic signed [63:0] m2_r [12];
  logic signed [63:0] m4_r [12];
  fix_t det;

  assign used     = (QCNT_W+1)'(q_count) + (QCNT_W+1)'($countones(v_r));
  assign in_ready = used < (QCNT_W+1)'(QDEPTH);
  assign acc      = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[FRONT_STAGES-2:0], acc};
    end
  end

  always_ff @(posedge clk) begin
    // stage 1: edges and origin offset
    dir1_r   <= in_dir;
    e1_1_r.x <= sub_sat(in_b.x, in_a.x);
    e1_1_r.y <= sub_sat(in_b.y, in_a.y);
    e1_1_r.z <= sub_sat(in_b.z, in_a.z);
    e2_1_r.x <= sub_sat(in_c.x, in_a.x);
    e2_1_r.y <= sub_sat(in_c.y, in_a.y);
    e2_1_r.z <= sub_sat(in_c.z, in_a.z);
    s1_r.x   <= sub_sat(cfg.origin.x, in_a.x);
    s1_r.y   <= sub_sat(cfg.origin.y, in_a.y);
    s1_r.z   <= sub_sat(cfg.origin.z, in_a.z);
    // stage 2: cross-product terms p = dir x e2, q = s x e1
    dir2_r <= dir1_r;
    e1_2_r <= e1_1_r;
    e2_2_r <= e2_1_r;
    s2_r   <= s1_r;
    m2_r[0]  <= fmul_raw(dir1_r.y, e2_1_r.z);
    m2_r[1]  <= fmul_raw(dir1_r.z, e2_1_r.y);
    m2_r[2]  <= fmul_raw(dir1_r.z, e2_1_r.x);
    m2_r[3]  <= fmul_raw(dir1_r.x, e2_1_r.z);
    m2_r[4]  <= fmul_raw(dir1_r.x, e2_1_r.y);
    m2_r[5]  <= fmul_raw(dir1_r.y, e2_1_r.x);
    m2_r[6]  <= fmul_raw(s1_r.y, e1_1_r.z);
    m2_r[7]  <= fmul_raw(s1_r.z, e1_1_r.y);
    m2_r[8]  <= fmul_raw(s1_r.z, e1_1_r.x);
    m2_r[9]  <= fmul_raw(s1_r.x, e1_1_r.z);
    m2_r[10] <= fmul_raw(s1_r.x, e1_1_r.y);
    m2_r[11] <= fmul_raw(s1_r.y, e1_1_r.x);
    // stage 3: cross products p and q completed
    p3_r.x <= sub_sat(fixp(m2_r[0]), fixp(m2_r[1]));
    p3_r.y <= sub_sat(fixp(m2_r[2]), fixp(m2_r[3]));
    p3_r.z <= sub_sat(fixp(m2_r[4]), fixp(m2_r[5]));
    q3_r.x <= sub_sat(fixp(m2_r[6]), fixp(m2_r[7]));
    q3_r.y <= sub_sat(fixp(m2_r[8]), fixp(m2_r[9]));
    q3_r.z <= sub_sat(fixp(m2_r[10]), fixp(m2_r[11]));
    // stage 4 products use stage-3 cross results and delayed vectors
    m4_r[0]  <= fmul_raw(e1_3_r.x, p3_r.x);
    m4_r[1]  <= fmul_raw(e1_3_r.y, p3_r.y);
    m4_r[2]  <= fmul_raw(e1_3_r.z, p3_r.z);
    m4_r[3]  <= fmul_raw(s3_r.x, p3_r.x);
    m4_r[4]  <= fmul_raw(s3_r.y, p3_r.y);
    m4_r[5]  <= fmul_raw(s3_r.z, p3_r.z);
    m4_r[6]  <= fmul_raw(dir3_r.x, q3_r.x);
    m4_r[7]  <= fmul_raw(dir3_r.y, q3_r.y);
    m4_r[8]  <= fmul_raw(dir3_r.z, q3_r.z);
    m4_r[9]  <= fmul_raw(e2_3_r.x, q3_r.x);
    m4_r[10] <= fmul_raw(e2_3_r.y, q3_r.y);
    m4_r[11] <= fmul_raw(e2_3_r.z, q3_r.z);
  end

  always_ff @(posedge clk) begin
    dir3_r <= dir2_r;
    e1_3_r <= e1_2_r;
    e2_3_r <= e2_2_r;
    s3_r   <= s2_r;
  end

  assign det  = add3_sat(fixp(m4_r[0]), fixp(m4_r[1]), fixp(m4_r[2]));
  assign push = v_r[FRONT_STAGES-1];

  always_comb begin
    push_data.det  = det;
    push_data.nu   = add3_sat(fixp(m4_r[3]), fixp(m4_r[4]), fixp(m4_r[5]));
    push_data.nv   = add3_sat(fixp(m4_r[6]), fixp(m4_r[7]), fixp(m4_r[8]));
    push_data.nt   = add3_sat(fixp(m4_r[9]), fixp(m4_r[10]), fixp(m4_r[11]));
    push_data.miss = (mag32(det) < {16'd0, cfg.eps}) || (det == '0);
  end

endmodule

// ===== hw/rtl/rti_queue.sv =====
// Short FIFO between front and back.
module rti_queue (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  rti_pkg::qent_t             push_data,
  input  logic                       pop,
  output rti_pkg::qent_t             head,
  output logic [rti_pkg::QCNT_W-1:0] count
);
  import rti_pkg::*;

  qent_t             mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_r, rd_r;
  logic [QCNT_W-1:0] cnt_r;

  assign head  = mem_r[rd_r];
  assign count = cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + QPTR_W'(1);
      if (pop) rd_r <= rd_r + QPTR_W'(1);
      cnt_r <= cnt_r + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_data;
  end

endmodule

// ===== hw/rtl/rti_back.sv =====
// Back: three pipelined restoring dividers, bound tests and the output register.
module rti_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  rti_pkg::qent_t             head,
  input  logic [rti_pkg::QCNT_W-1:0] q_count,
  output logic                       pop,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_hit,
  output rti_pkg::fix_t              out_distance,
  output rti_pkg::fix_t              out_bary_u,
  output rti_pkg::fix_t              out_bary_v
);
  import rti_pkg::*;

  typedef struct packed {
    logic             miss;
    logic [2:0]       neg;
    logic [FIX_W-1:0] dmag;
  } bctl_t;

  bctl_t         ctl_r  [NUM_W+1];
  div_lane_t     ln_r   [NUM_W+1][3];
  logic [NUM_W:0] v_r;
  logic          en;
  fix_t          u, v, t;
  logic signed [FIX_W+1:0] su, sv, uv;
  logic          hit;

  assign en  = !out_valid || out_ready;
  assign pop = en && (q_count != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r       <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      v_r       <= {v_r[NUM_W-1:0], pop};
      out_valid <= v_r[NUM_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_r[0].miss <= head.miss;
      ctl_r[0].neg  <= {head.nt[FIX_W-1] ^ head.det[FIX_W-1],
                        head.nv[FIX_W-1] ^ head.det[FIX_W-1],
                        head.nu[FIX_W-1] ^ head.det[FIX_W-1]};
      // a missed item still runs; keep its divisor nonzero
      ctl_r[0].dmag <= head.miss ? FIX_W'(1) : mag32(head.det);
      ln_r[0][0] <= '{num: {mag32(head.nu), FRAC_BITS'(0)}, quo: '0, rem: '0};
      ln_r[0][1] <= '{num: {mag32(head.nv), FRAC_BITS'(0)}, quo: '0, rem: '0};
      ln_r[0][2] <= '{num: {mag32(head.nt), FRAC_BITS'(0)}, quo: '0, rem: '0};
      for (int k = 1; k <= NUM_W; k++) begin
        ctl_r[k] <= ctl_r[k-1];
        for (int j = 0; j < 3; j++) begin
          ln_r[k][j] <= div_step(ln_r[k-1][j], ctl_r[k-1].dmag);
        end
      end
    end
  end

  always_comb begin
    u  = quo_sat(ln_r[NUM_W][0].quo, ctl_r[NUM_W].neg[0]);
    v  = quo_sat(ln_r[NUM_W][1].quo, ctl_r[NUM_W].neg[1]);
    t  = quo_sat(ln_r[NUM_W][2].quo, ctl_r[NUM_W].neg[2]);
    su = (FIX_W+2)'(u);
    sv = (FIX_W+2)'(v);
    uv = su + sv;
    hit = !ctl_r[NUM_W].miss && !u[FIX_W-1] && (su <= FIX_ONE)
          && !v[FIX_W-1] && (uv <= FIX_ONE);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_hit      <= hit;
      out_distance <= hit ? t : '0;
      out_bary_u   <= hit ? u : '0;
      out_bary_v   <= hit ? v : '0;
    end
  end

endmodule

// ===== hw/rtl/ray_triangle_intersect.sv =====
// Top level of the Moller-Trumbore ray/triangle intersect block.
//  channel  | dir | beat
//  in_ch    | in  | ray direction and triangle vertices a, b, c
//  out_ch   | out | hit, distance, bary_u, bary_v
//  cfg_ch   | in  | register index and write data (origin x/y/z, det epsilon)
// One beat per cycle sustained while out_ch is not stalled; a beat passes the front stages,
// the queue, one divider stage per quotient bit (32 + FRAC_BITS) and the output register.
// Reset is synchronous; config registers return to origin 0 and epsilon 7.
// The 8-entry queue lets the front keep taking beats while the output is stalled;
// in_ch.ready drops once queued plus in-flight front beats would fill it.
module ray_triangle_intersect (
  input logic clk,
  input logic rst_n,
  rti_in_if.sink    in_ch,
  rti_out_if.source out_ch,
  rti_cfg_if.sink   cfg_ch
);
  import rti_pkg::*;

  cfg_t              cfg_r;
  qent_t             push_data, head;
  logic              push, pop;
  logic [QCNT_W-1:0] q_count;
  vec_t              dir, va, vb, vc;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.origin <= '0;
      cfg_r.eps    <= DET_EPS_RESET;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_ORIGIN_X:    cfg_r.origin.x <= cfg_ch.data;
        REG_ORIGIN_Y:    cfg_r.origin.y <= cfg_ch.data;
        REG_ORIGIN_Z:    cfg_r.origin.z <= cfg_ch.data;
        REG_DET_EPSILON: cfg_r.eps      <= cfg_ch.data[15:0];
        default: ;
      endcase
    end
  end

  assign dir = '{x: in_ch.dir_x, y: in_ch.dir_y, z: in_ch.dir_z};
  assign va  = '{x: in_ch.a_x, y: in_ch.a_y, z: in_ch.a_z};
  assign vb  = '{x: in_ch.b_x, y: in_ch.b_y, z: in_ch.b_z};
  assign vc  = '{x: in_ch.c_x, y: in_ch.c_y, z: in_ch.c_z};

  rti_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_dir    (dir),
    .in_a      (va),
    .in_b      (vb),
    .in_c      (vc),
    .cfg       (cfg_r),
    .q_count   (q_count),
    .push      (push),
    .push_data (push_data)
  );

  rti_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .count     (q_count)
  );

  rti_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head         (head),
    .q_count      (q_count),
    .pop          (pop),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_hit      (out_ch.hit),
    .out_distance (out_ch.distance),
    .out_bary_u   (out_ch.bary_u),
    .out_bary_v   (out_ch.bary_v)
  );

endmodule

// ===== verif/rti_tb_if.sv =====
// Testbench-side view: none needed beyond the RTL interfaces; holds the expected-result and ray beat types.
`timescale 1ns / 100ps
package rti_tb_pkg;
  import rti_pkg::*;

  typedef struct packed {
    logic hit;
    fix_t distance;
    fix_t bary_u;
    fix_t bary_v;
  } isect_t;

  typedef struct packed {
    fix_t dx, dy, dz, ax, ay, az, bx, by, bz, cx, cy, cz;
  } tri_beat_t;
endpackage

// ===== verif/ray_triangle_intersect_tb.sv =====
// Self-checking bench for ray_triangle_intersect: directed and random rays, scored against a predictor.
`timescale 1ns / 100ps
module ray_triangle_intersect_tb;
  import rti_pkg::*;
  import rti_tb_pkg::*;

  localparam longint S_MAX = 64'sd2147483647;
  localparam longint S_MIN = -64'sd2147483648;
  localparam int LIMIT = 400000;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = CFG_IDX_W'(9);

  logic clk = 0;
  logic rst_n = 0;

  rti_in_if  in_ch();
  rti_out_if out_ch();
  rti_cfg_if cfg_ch();

  ray_triangle_intersect DUT (.clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink),
                              .out_ch(out_ch.source), .cfg_ch(cfg_ch.sink));

  // predictor copy of the registers
  longint org_x, org_y, org_z, eps;

  tri_beat_t pending_rays[$];
  isect_t    expected_hits[$];
  int errors = 0, cycles = 0, beats_in = 0, beats_out = 0, hits_seen = 0;
  int in_gap = 0, out_gap = 0;
  bit feeding = 0;

  initial forever #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout at cycle %0d", cycles);
      $display("ray_triangle_intersect_tb: done, errors");
      $finish;
    end
  end

  function automatic longint sat(longint x);
    return x > S_MAX ? S_MAX : (x < S_MIN ? S_MIN : x);
  endfunction

  function automatic longint fprod(longint a, longint b);
    return sat((a * b) >>> FRAC_BITS);
  endfunction

  function automatic longint quot(longint n, longint d);
    return sat((n * (64'sd1 <<< FRAC_BITS)) / d);
  endfunction

  function automatic isect_t predict(tri_beat_t r);
    longint d[3], a[3], e1[3], e2[3], s[3], p[3], q[3], o[3];
    longint det, u, v, t, one;
    isect_t res;
    one = 64'sd1 <<< FRAC_BITS;
    res = '0;
    d = '{r.dx, r.dy, r.dz};
    a = '{r.ax, r.ay, r.az};
    o = '{org_x, org_y, org_z};
    e1 = '{sat(r.bx - a[0]), sat(r.by - a[1]), sat(r.bz - a[2])};
    e2 = '{sat(r.cx - a[0]), sat(r.cy - a[1]), sat(r.cz - a[2])};
    for (int i = 0; i < 3; i++) s[i] = sat(o[i] - a[i]);
    p[0] = sat(fprod(d[1], e2[2]) - fprod(d[2], e2[1]));
    p[1] = sat(fprod(d[2], e2[0]) - fprod(d[0], e2[2]));
    p[2] = sat(fprod(d[0], e2[1]) - fprod(d[1], e2[0]));
    det = sat(fprod(e1[0], p[0]) + fprod(e1[1], p[1]) + fprod(e1[2], p[2]));
    if ((det < 0 ? -det : det) < eps || det == 0) return res;
    u = quot(sat(fprod(s[0], p[0]) + fprod(s[1], p[1]) + fprod(s[2], p[2])), det);
    if (u < 0 || u > one) return res;
    q[0] = sat(fprod(s[1], e1[2]) - fprod(s[2], e1[1]));
    q[1] = sat(fprod(s[2], e1[0]) - fprod(s[0], e1[2]));
    q[2] = sat(fprod(s[0], e1[1]) - fprod(s[1], e1[0]));
    v = quot(sat(fprod(d[0], q[0]) + fprod(d[1], q[1]) + fprod(d[2], q[2])), det);
    if (v < 0 || u + v > one) return res;
    t = quot(sat(fprod(e2[0], q[0]) + fprod(e2[1], q[1]) + fprod(e2[2], q[2])), det);
    res.hit = 1'b1;
    res.distance = fix_t'(t);
    res.bary_u = fix_t'(u);
    res.bary_v = fix_t'(v);
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("mismatch beat %0d %s: got %h want %h", beats_out, what, got, want);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && !in_ch.ready) begin
      // hold
    end else begin
      if (in_ch.valid) begin
        expected_hits.push_back(predict({in_ch.dir_x, in_ch.dir_y, in_ch.dir_z,
            in_ch.a_x, in_ch.a_y, in_ch.a_z, in_ch.b_x, in_ch.b_y, in_ch.b_z,
            in_ch.c_x, in_ch.c_y, in_ch.c_z}));
        beats_in <= beats_in + 1;
      end
      if (feeding && in_gap == 0 && pending_rays.size() > 0) begin
        tri_beat_t r;
        r = pending_rays.pop_front();
        in_ch.valid <= 1'b1;
        {in_ch.dir_x, in_ch.dir_y, in_ch.dir_z, in_ch.a_x, in_ch.a_y, in_ch.a_z,
         in_ch.b_x, in_ch.b_y, in_ch.b_z, in_ch.c_x, in_ch.c_y, in_ch.c_z} <= r;
        in_gap <= pick_gap();
      end else begin
        in_ch.valid <= 1'b0;
        if (in_gap > 0) in_gap <= in_gap - 1;
      end
    end
  end

  // monitor and result-side stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        isect_t w;
        beats_out <= beats_out + 1;
        if (expected_hits.size() == 0) begin
          report("unexpected beat", 32'(out_ch.hit), '0);
        end else begin
          w = expected_hits.pop_front();
          if (w.hit) hits_seen <= hits_seen + 1;
          if (out_ch.hit !== w.hit) report("hit", 32'(out_ch.hit), 32'(w.hit));
          if (out_ch.distance !== w.distance) report("distance", out_ch.distance, w.distance);
          if (out_ch.bary_u !== w.bary_u) report("bary_u", out_ch.bary_u, w.bary_u);
          if (out_ch.bary_v !== w.bary_v) report("bary_v", out_ch.bary_v, w.bary_v);
        end
      end
      if (out_gap > 0) begin
        out_ch.ready <= 1'b0;
        out_gap <= out_gap - 1;
      end else begin
        out_ch.ready <= 1'b1;
        out_gap <= pick_gap();
      end
    end
  end

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    cfg_ch.valid <= 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      REG_ORIGIN_X:    org_x = longint'(signed'(val));
      REG_ORIGIN_Y:    org_y = longint'(signed'(val));
      REG_ORIGIN_Z:    org_z = longint'(signed'(val));
      REG_DET_EPSILON: eps = val[15:0];
      default: ;
    endcase
    // let valid fall before the next write so back-to-back writes never drive valid twice in a step
    @(posedge clk);
  endtask

  task automatic set_origin(int x, int y, int z, logic [15:0] e);
    cfg_write(REG_ORIGIN_X, x);
    cfg_write(REG_ORIGIN_Y, y);
    cfg_write(REG_ORIGIN_Z, z);
    cfg_write(REG_DET_EPSILON, {16'd0, e});
  endtask

  // drain queue and wait out the pipeline before touching registers
  task automatic drain();
    do @(posedge clk); while (pending_rays.size() > 0 || in_ch.valid);
    feeding = 0;
    do @(posedge clk); while (expected_hits.size() > 0);
    repeat (NUM_W + 20) @(posedge clk);
  endtask

  function automatic int fx(int lo, int hi);
    return $urandom_range(hi - lo, 0) + lo;
  endfunction

  function automatic int wild();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 0;
      default: return $urandom;
    endcase
  endfunction

  // well-formed ray aimed into a triangle near origin, random scale
  function automatic tri_beat_t aimed_ray(int span);
    tri_beat_t r;
    r.ax = fx(-span, span); r.ay = fx(-span, span); r.az = fx(-span, span);
    r.bx = r.ax + fx(-span, span); r.by = r.ay + fx(-span, span); r.bz = r.az + fx(-span, span);
    r.cx = r.ax + fx(-span, span); r.cy = r.ay + fx(-span, span); r.cz = r.az + fx(-span, span);
    // direction toward a point inside the triangle
    r.dx = (r.ax + r.bx + r.cx) / 3 - int'(org_x) + fx(-span/4, span/4);
    r.dy = (r.ay + r.by + r.cy) / 3 - int'(org_y) + fx(-span/4, span/4);
    r.dz = (r.az + r.bz + r.cz) / 3 - int'(org_z) + fx(-span/4, span/4);
    return r;
  endfunction

  function automatic tri_beat_t noise_ray();
    tri_beat_t r;
    r = {wild(), wild(), wild(), wild(), wild(), wild(),
         wild(), wild(), wild(), wild(), wild(), wild()};
    return r;
  endfunction

  task automatic run_random(int n, int span);
    for (int i = 0; i < n; i++)
      pending_rays.push_back($urandom_range(0, 9) < 8 ? aimed_ray(span) : noise_ray());
    feeding = 1;
    drain();
  endtask

  initial begin
    tri_beat_t r;
    int span;
    org_x = 0; org_y = 0; org_z = 0; eps = DET_EPS_RESET;
    in_ch.valid = 0;
    {in_ch.dir_x, in_ch.dir_y, in_ch.dir_z, in_ch.a_x, in_ch.a_y, in_ch.a_z,
     in_ch.b_x, in_ch.b_y, in_ch.b_z, in_ch.c_x, in_ch.c_y, in_ch.c_z} = '0;
    out_ch.ready = 0;
    cfg_ch.valid = 0; cfg_ch.index = '0; cfg_ch.data = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, reset registers: unit triangle at z = 1 seen from origin
    r = '{32'h0000_4000, 32'h0000_4000, 32'h0001_0000, 0, 0, 32'h0001_0000,
          32'h0001_0000, 0, 32'h0001_0000, 0, 32'h0001_0000, 32'h0001_0000};
    pending_rays.push_back(r);
    r.dz = -32'sh0001_0000; pending_rays.push_back(r);           // dz flipped: u comes out negative, a miss
    r.dz = 32'h0001_0000; r.dx = 32'h0002_0000; pending_rays.push_back(r); // u too big
    r.dx = -32'sh0000_1000; pending_rays.push_back(r);          // u negative
    r.dx = 32'h0000_C000; r.dy = 32'h0000_C000; pending_rays.push_back(r); // u+v over one
    r.dx = 0; r.dy = 0; pending_rays.push_back(r);              // corner: u = v = 0
    r = '{32'h0001_0000, 0, 0, 0, 0, 0, 32'h0001_0000, 0, 0, 0, 32'h0001_0000, 0};
    pending_rays.push_back(r);                                  // parallel: det zero
    r = '{32'h0000_0001, 32'h0000_0001, 32'h0000_0001, 0, 0, 32'h0000_0004,
          32'h0000_0004, 0, 32'h0000_0004, 0, 32'h0000_0004, 32'h0000_0004};
    pending_rays.push_back(r);                                  // tiny det below epsilon
    pending_rays.push_back('1);
    pending_rays.push_back({12{32'h8000_0000}});
    pending_rays.push_back({12{32'h7FFF_FFFF}});
    pending_rays.push_back({6{32'h7FFF_FFFF, 32'h8000_0000}});
    pending_rays.push_back({6{32'h8000_0000, 32'h7FFF_FFFF}});
    feeding = 1;
    drain();

    // epsilon zero: only exact zero determinant misses
    set_origin(0, 0, 0, 16'h0000);
    pending_rays.push_back(r);
    pending_rays.push_back('0);
    feeding = 1;
    drain();
    cfg_write(REG_UNMAPPED, 32'hDEAD_BEEF);   // beyond the register map: ignored

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_origin(32'h7FFF_FFFF, 32'h8000_0000, 0, 16'hFFFF);
        1: set_origin(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 16'h0000);
        default: set_origin(fx(-32'sh0008_0000, 32'sh0008_0000),
                            fx(-32'sh0008_0000, 32'sh0008_0000),
                            fx(-32'sh0008_0000, 32'sh0008_0000),
                            16'($urandom_range(0, 300)));
      endcase
      span = (ph % 3 == 0) ? 32'h0200_0000 : 32'h0008_0000;
      run_random(160, span);
    end

    $display("covered %0d ray beats, %0d results, %0d hits", beats_in, beats_out, hits_seen);
    $display("phases: directed edge cases, epsilon extremes, 8 random origin settings");
    if (errors == 0) begin
      $display("ray_triangle_intersect_tb: done, clean");
    end else begin
      $display("ray_triangle_intersect_tb: done, errors");
    end
    $finish;
  end
endmodule
